@@ rtl/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int COUNT_W      = 7;

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic               func;
        logic [31:0]        handle_in;
        logic [7:0]         kind_in;
        logic signed [15:0] priority_in;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic [31:0]        handle_out;
        logic [7:0]         kind_out;
        logic signed [15:0] priority_out;
    } t_out_beat;

    typedef struct packed {
        logic [31:0]        handle;
        logic [7:0]         kind;
        logic signed [15:0] prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

@@ rtl/spq_if.sv @@
`default_nettype none

interface spq_in_if;
    import spq_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/spq_ram.sv @@
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
`default_nettype none

module spq_ctrl #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    spq_in_if.sink                      i_in,
    spq_out_if.source                   o_out,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [spq_pkg::ENTRY_W-1:0] o_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    input  logic [spq_pkg::ENTRY_W-1:0] i_rdata
);
    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_POP   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_PUT   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_wr_idx, n_wr_idx;
    logic      r_dup, n_dup;
    logic      r_cmp_vld, n_cmp_vld;
    logic      r_wr_pend, n_wr_pend;
    t_entry    r_req, n_req;
    t_out_beat r_res, n_res;
    t_out_beat r_out, n_out;
    logic      r_out_vld, n_out_vld;

    t_entry        rd_entry;
    logic [CW-1:0] rd_log;
    logic [CW-1:0] wr_log;
    logic          can_load;

    // logical position in the sorted list to ring address
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + (AW+1)'(idx);
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_entry    = i_rdata;
    assign can_load    = !r_out_vld || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
    assign o_raddr     = f_phys(r_head, rd_log);
    assign o_waddr     = f_phys(r_head, wr_log);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_wr_idx  = r_wr_idx;
        n_dup     = r_dup;
        n_cmp_vld = r_cmp_vld;
        n_wr_pend = r_wr_pend;
        n_req     = r_req;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        rd_log    = '0;
        wr_log    = r_pos;
        o_we      = 1'b0;
        o_wdata   = r_req;

        if (o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                n_res = '0;
                n_res.count = COUNT_W'(r_count);
                if (i_in.valid) begin
                    if (i_in.data.func == FN_REMOVE) begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_POP;
                        end
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_res.status = ST_FULL;
                        n_state = S_FIN;
                    end else begin
                        n_req.handle = i_in.data.handle_in;
                        n_req.kind   = i_in.data.kind_in;
                        n_req.prio   = i_in.data.priority_in;
                        n_idx     = '0;
                        n_pos     = '0;
                        n_dup     = 1'b0;
                        n_cmp_vld = 1'b0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_POP: begin
                n_count = r_count - 1'b1;
                n_head  = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
                n_res.status       = ST_OK;
                n_res.count        = COUNT_W'(n_count);
                n_res.handle_out   = rd_entry.handle;
                n_res.kind_out     = rd_entry.kind;
                n_res.priority_out = rd_entry.prio;
                n_state = S_FIN;
            end
            S_SCAN: begin
                // entries are sorted, so the slot is the count of entries at or below
                if (r_cmp_vld) begin
                    if (rd_entry.handle == r_req.handle) begin
                        n_dup = 1'b1;
                    end
                    if (rd_entry.prio <= r_req.prio) begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                rd_log = r_idx;
                if (r_idx != r_count) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                    if (!r_cmp_vld) begin
                        if (r_dup) begin
                            n_res.status = ST_DUP;
                            n_state = S_FIN;
                        end else begin
                            n_idx     = r_count;
                            n_wr_pend = 1'b0;
                            n_state   = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // move the tail down one slot, last entry first
                rd_log = r_idx - 1'b1;
                if (r_wr_pend) begin
                    o_we    = 1'b1;
                    wr_log  = r_wr_idx;
                    o_wdata = rd_entry;
                end
                if (r_idx != r_pos) begin
                    n_wr_idx  = r_idx;
                    n_idx     = r_idx - 1'b1;
                    n_wr_pend = 1'b1;
                end else begin
                    n_wr_pend = 1'b0;
                    if (!r_wr_pend) begin
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                o_we    = 1'b1;
                wr_log  = r_pos;
                o_wdata = r_req;
                n_count = r_count + 1'b1;
                n_res.status = ST_OK;
                n_res.count  = COUNT_W'(n_count);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (can_load) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_wr_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_wr_pend <= n_wr_pend;
            r_out_vld <= n_out_vld;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_wr_idx <= n_wr_idx;
        r_dup    <= n_dup;
        r_req    <= n_req;
        r_res    <= n_res;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire

@@ rtl/stable_priority_queue.sv @@
`default_nettype none

// Bounded priority queue of CAPACITY entries kept in ascending priority order in one
// single-port-read, single-port-write RAM used as a ring (removal advances the head).
// An insert scans all n queued entries for a duplicate handle and its slot, then moves
// the n - pos entries behind the slot down one place and writes the new entry. Full,
// empty or duplicate cases end after the scan or at once. One item is in flight at a
// time; a finished result waits in the output register while the next beat is taken.
// The RAM needs no clearing after reset.
module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata)
    );

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ tb/stable_priority_queue_tb.sv @@
`timescale 1ns / 100ps

module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 200;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  in_bus ();
    spq_out_if out_bus ();

    stable_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_in_beat  beats_to_send[$];
    t_out_beat predicted_replies[$];
    t_entry    pq_model[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit rx_hold       = 0;
    int mismatch_count = 0;
    int cycle_count   = 0;

    t_out_beat want_reply;
    t_out_beat got_reply;

    function automatic t_out_beat pq_apply(t_in_beat b);
        t_out_beat r;
        t_entry    e;
        bit        dup;
        int        pos;
        r   = '0;
        dup = 0;
        pos = 0;
        if (b.func == FN_INSERT) begin
            // full is tested before the duplicate scan
            if (pq_model.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                foreach (pq_model[i])
                    if (pq_model[i].handle == b.handle_in) dup = 1;
                if (dup) begin
                    r.status = ST_DUP;
                end else begin
                    // go behind every entry of equal or lower priority
                    while (pos < pq_model.size() &&
                           $signed(b.priority_in) >= $signed(pq_model[pos].prio))
                        pos++;
                    e.handle = b.handle_in;
                    e.kind   = b.kind_in;
                    e.prio   = b.priority_in;
                    pq_model.insert(pos, e);
                    r.status = ST_OK;
                end
            end
        end else begin
            if (pq_model.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                e = pq_model.pop_front();
                r.status       = ST_OK;
                r.handle_out   = e.handle;
                r.kind_out     = e.kind;
                r.priority_out = e.prio;
            end
        end
        r.count = COUNT_W'(pq_model.size());
        return r;
    endfunction

    function automatic t_in_beat make_item(int insert_pct);
        t_in_beat b;
        b.func        = ($urandom_range(99) < insert_pct) ? FN_INSERT : FN_REMOVE;
        // a small handle pool now and then to provoke duplicates
        b.handle_in   = ($urandom_range(3) == 0) ? 32'($urandom_range(127)) : $urandom();
        b.kind_in     = 8'($urandom_range(255));
        // narrow priorities give plenty of ties
        b.priority_in = ($urandom_range(1) == 0) ? 16'($urandom_range(8)) - 16'd4
                                                 : 16'($urandom());
        return b;
    endfunction

    task automatic add_beat(logic fn, logic [31:0] h, logic [7:0] k, logic [15:0] p);
        t_in_beat b;
        b.func        = fn;
        b.handle_in   = h;
        b.kind_in     = k;
        b.priority_in = p;
        beats_to_send.push_back(b);
    endtask

    task automatic add_random(int n, int insert_pct);
        repeat (n) beats_to_send.push_back(make_item(insert_pct));
    endtask

    task automatic wait_drained();
        while (beats_to_send.size() != 0 || predicted_replies.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic report(string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stable_priority_queue_tb: errors");
            $finish;
        end
    end

    // driver: keep a beat on offer until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (in_bus.valid && !in_bus.ready) begin
            // hold the current beat
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                predicted_replies.push_back(pq_apply(in_bus.data));
                void'(beats_to_send.pop_front());
            end
            if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_bus.valid <= 1'b1;
                in_bus.data  <= beats_to_send[0];
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got_reply = out_bus.data;
                if (predicted_replies.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want_reply = predicted_replies.pop_front();
                    if (got_reply.status != want_reply.status)
                        report($sformatf("status got %0d want %0d",
                                         got_reply.status, want_reply.status));
                    if (got_reply.count != want_reply.count)
                        report($sformatf("count got %0d want %0d",
                                         got_reply.count, want_reply.count));
                    if (got_reply.handle_out != want_reply.handle_out)
                        report($sformatf("handle got %h want %h",
                                         got_reply.handle_out, want_reply.handle_out));
                    if (got_reply.kind_out != want_reply.kind_out)
                        report($sformatf("kind got %h want %h",
                                         got_reply.kind_out, want_reply.kind_out));
                    if (got_reply.priority_out != want_reply.priority_out)
                        report($sformatf("priority got %0d want %0d",
                                         got_reply.priority_out, want_reply.priority_out));
                end
            end
            out_bus.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_bus.valid  = 1'b0;
        in_bus.data   = '0;
        out_bus.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty remove, extremes, ties, duplicates, drain past empty
        add_beat(FN_REMOVE, 32'h0,        8'h00, 16'h0000);
        add_beat(FN_INSERT, 32'h0,        8'h00, 16'h8000);
        add_beat(FN_INSERT, 32'hFFFFFFFF, 8'hFF, 16'h7FFF);
        add_beat(FN_INSERT, 32'hA5A5A5A5, 8'h5A, 16'h0000);
        add_beat(FN_INSERT, 32'h5A5A5A5A, 8'hA5, 16'h0000);
        add_beat(FN_INSERT, 32'h0,        8'h11, 16'h0005);
        add_beat(FN_INSERT, 32'hFFFFFFFF, 8'h22, 16'hFFFF);
        add_beat(FN_INSERT, 32'h1,        8'h01, 16'hFFFF);
        add_beat(FN_INSERT, 32'h2,        8'h02, 16'h8000);
        add_beat(FN_INSERT, 32'h3,        8'h03, 16'h7FFF);
        repeat (8) add_beat(FN_REMOVE, 32'hFFFFFFFF, 8'hFF, 16'hFFFF);
        add_beat(FN_INSERT, 32'h0,        8'h7E, 16'h0001);
        add_beat(FN_REMOVE, 32'h0,        8'h00, 16'h0000);
        add_beat(FN_REMOVE, 32'h0,        8'h00, 16'h0000);
        wait_drained();

        add_random(60, 50);
        wait_drained();

        // fill past capacity with the sender mostly idle
        send_idle_pct = 84;
        add_random(100, 90);
        wait_drained();

        // drain past empty with the receiver mostly stalled
        send_idle_pct = 0;
        stall_pct     = 84;
        add_random(100, 15);
        wait_drained();

        send_idle_pct = 19;
        stall_pct     = 19;
        add_random(100, 55);
        wait_drained();

        // back up the result side while beats keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        rx_hold       = 1'b1;
        add_random(40, 60);
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold = 1'b0;
        wait_drained();

        repeat (SETTLE) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("stable_priority_queue_tb: clean");
        end else begin
            $display("stable_priority_queue_tb: errors");
        end
        $finish;
    end

endmodule
